FILE: design/hist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hist_pkg: shared constants and types of the histogram engine
// Field widths, fixed-point constants, command, status and register codes.
// ----------------------------------------------------------------------------
package hist_pkg;

    localparam int BINS_DEF   = 256;

    localparam int CMD_W      = 3;
    localparam int SAMP_W     = 16;
    localparam int IDX_IN_W   = 8;
    localparam int FACT_W     = 32;
    localparam int DATA_W     = 40;
    localparam int STAT_W     = 2;
    localparam int BCNT_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int BIN_W      = 32;
    localparam int FRAC_W     = 8;
    localparam int SCALE_SH   = 16;
    localparam int PROD_W     = BIN_W + FACT_W;
    localparam int DEN_W_DEF  = BIN_W + $clog2(BINS_DEF) + 1 + FRAC_W;

    // 1.0 in 24.8
    localparam logic [BIN_W-1:0]  BIN_ONE  = BIN_W'(1 << FRAC_W);
    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (SCALE_SH - 1);
    localparam logic [DATA_W-1:0] DATA_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_FILL      = 3'd0,
        CMD_READ      = 3'd1,
        CMD_INTEGRAL  = 3'd2,
        CMD_SCALE     = 3'd3,
        CMD_NORMALIZE = 3'd4,
        CMD_CLEAR     = 3'd5
    } cmd_t;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 2'd2;

endpackage

FILE: design/hist_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hist_ram: bin store
// Single-port synchronous memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module hist_ram #(
    parameter int DEPTH  = hist_pkg::BINS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          addr,
    input  logic [hist_pkg::BIN_W-1:0] wdata,
    output logic [hist_pkg::BIN_W-1:0] rdata
);
    import hist_pkg::*;

    logic [BIN_W-1:0] mem [DEPTH];
    logic [BIN_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/hist_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hist_div: rounding divider for normalize
// Restoring division, one quotient bit per cycle, then round half up and
// saturate the quotient to the bin width.
// ----------------------------------------------------------------------------
module hist_div #(
    parameter int DEN_W = hist_pkg::DEN_W_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [hist_pkg::PROD_W-1:0] num,
    input  logic [DEN_W-1:0]            den,
    output logic                        done,
    output logic [hist_pkg::BIN_W-1:0]  quo
);
    import hist_pkg::*;

    localparam int STEP_W = $clog2(PROD_W);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PROD_W-1:0] num_reg, num_next;
    logic [PROD_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_sub;
    logic              rnd;
    logic [PROD_W:0]   q_rnd;

    assign rem_sh  = {rem_reg, num_reg[PROD_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = STEP_W'(PROD_W - 1);
            num_next  = num;
            den_next  = den;
            q_next    = '0;
            rem_next  = '0;
        end
        else if (run_reg)
        begin
            num_next = num_reg << 1;
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sub[DEN_W-1:0];
                q_next   = {q_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DEN_W-1:0];
                q_next   = {q_reg[PROD_W-2:0], 1'b0};
            end
            if (step_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    // ties go up: 2 * rem >= den
    assign rnd   = {rem_reg, 1'b0} >= {1'b0, den_reg};
    assign q_rnd = {1'b0, q_reg} + (PROD_W + 1)'(rnd);
    assign quo   = (|q_rnd[PROD_W:BIN_W]) ? '1 : q_rnd[BIN_W-1:0];
    assign done  = done_reg;

endmodule

FILE: design/histogram_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_engine: fixed-point histogram store
// Bins in unsigned 24.8 held in one synchronous memory; fill, read, integral,
// scale, normalize and clear commands, one result beat per input beat.
// ----------------------------------------------------------------------------
// One command at a time; every bin access goes through the single memory
// port, so n active bins bound the whole-store commands. Fill reads the bin
// and writes it back incremented; read returns the addressed bin; a rejected
// sample or an unused command is answered from the idle state. Integral sums
// the n active bins. Scale reads, multiplies 32x32 and writes back each bin.
// Normalize runs the same sum pass, then per bin a read, a multiply and a
// division in the one-bit-per-cycle divider, then finishes. Clear writes all
// BINS bins. After reset a clearing pass over all BINS bins runs before the
// first input beat is taken; configuration writes are taken at any time. A
// result waiting on out_stall holds the engine until it is taken.
module histogram_engine #(
    parameter int BINS = hist_pkg::BINS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write,
    input  logic [hist_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hist_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [hist_pkg::CMD_W-1:0]          command,
    input  logic signed [hist_pkg::SAMP_W-1:0]  sample_value,
    input  logic [hist_pkg::IDX_IN_W-1:0]       bin_index,
    input  logic [hist_pkg::FACT_W-1:0]         factor,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [hist_pkg::DATA_W-1:0]         data,
    output logic [hist_pkg::STAT_W-1:0]         status
);
    import hist_pkg::*;

    localparam int IDX_W = $clog2(BINS);
    localparam int CNT_W = IDX_W + 1;
    localparam int SUM_W = BIN_W + IDX_W + 1;
    localparam int DEN_W = SUM_W + FRAC_W;

    typedef enum logic [12:0] {
        ST_CLR     = 13'b0000000000001,
        ST_IDLE    = 13'b0000000000010,
        ST_FILL    = 13'b0000000000100,
        ST_READ    = 13'b0000000001000,
        ST_SUM     = 13'b0000000010000,
        ST_SCL_RD  = 13'b0000000100000,
        ST_SCL_MUL = 13'b0000001000000,
        ST_SCL_WR  = 13'b0000010000000,
        ST_NRM_RD  = 13'b0000100000000,
        ST_NRM_MUL = 13'b0001000000000,
        ST_NRM_GO  = 13'b0010000000000,
        ST_NRM_DIV = 13'b0100000000000,
        ST_RESP    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [SAMP_W-1:0] range_low_reg, range_high_reg;
    logic [BCNT_W-1:0]        bin_count_reg;

    logic [CNT_W-1:0]  k_reg, k_next;
    logic              pend_reg, pend_next;
    logic              clr_resp_reg, clr_resp_next;
    logic              nrm_reg, nrm_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [FACT_W-1:0] factor_reg, factor_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] res_data_reg, res_data_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;

    logic              fin;
    logic [DATA_W-1:0] fin_data;
    logic [STAT_W-1:0] fin_status;
    logic              out_free;
    logic              in_fire;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_addr;
    logic [BIN_W-1:0]  mem_wdata;
    logic [BIN_W-1:0]  mem_rdata;

    logic              div_start;
    logic              div_done;
    logic [BIN_W-1:0]  div_quo;

    logic [CNT_W-1:0]         act_n;
    logic signed [SAMP_W:0]   diff_s;
    logic [SAMP_W-1:0]        diff_u;
    logic                     fill_ok;
    logic [SAMP_W-1:0]        rd_ext;
    logic                     rd_ok;
    logic [BIN_W:0]           fill_sum;
    logic [BIN_W-1:0]         fill_sat;
    logic [PROD_W-1:0]        mul_res;
    logic [PROD_W-1:0]        scl_rnd;
    logic [BIN_W-1:0]         scl_q;
    logic [DATA_W-1:0]        sum_sat;

    hist_ram #(
        .DEPTH  (BINS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    hist_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   ({sum_reg, FRAC_W'(0)}),
        .done  (div_done),
        .quo   (div_quo)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '0;
            range_high_reg <= SAMP_W'(256);
            bin_count_reg  <= BCNT_W'(256);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RANGE_LOW:  range_low_reg  <= signed'(cfg_data);
                CFG_RANGE_HIGH: range_high_reg <= signed'(cfg_data);
                CFG_BIN_COUNT:  bin_count_reg  <= cfg_data[BCNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (32'(bin_count_reg) >= 32'(BINS))
        begin
            act_n = CNT_W'(BINS);
        end
        else
        begin
            act_n = CNT_W'(bin_count_reg);
        end
    end

    assign diff_s  = {sample_value[SAMP_W-1], sample_value}
                   - {range_low_reg[SAMP_W-1], range_low_reg};
    assign diff_u  = diff_s[SAMP_W-1:0];
    assign fill_ok = (sample_value >= range_low_reg) && (sample_value < range_high_reg)
                   && (32'(diff_u) < 32'(act_n));
    assign rd_ext  = SAMP_W'(bin_index);
    assign rd_ok   = 32'(bin_index) < 32'(BINS);

    assign fill_sum = {1'b0, mem_rdata} + {1'b0, BIN_ONE};
    assign fill_sat = fill_sum[BIN_W] ? '1 : fill_sum[BIN_W-1:0];
    assign mul_res  = 64'(mem_rdata) * 64'(factor_reg);
    assign scl_rnd  = prod_reg + RND_HALF;
    assign scl_q    = (|scl_rnd[PROD_W-1:SCALE_SH+BIN_W]) ? '1
                    : scl_rnd[SCALE_SH+BIN_W-1:SCALE_SH];
    assign sum_sat  = (64'(sum_reg) > 64'(DATA_MAX)) ? DATA_MAX : DATA_W'(sum_reg);

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = state_reg != ST_IDLE;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        pend_next       = 1'b0;
        clr_resp_next   = clr_resp_reg;
        nrm_next        = nrm_reg;
        idx_next        = idx_reg;
        factor_next     = factor_reg;
        sum_next        = sum_reg;
        prod_next       = prod_reg;
        fin             = 1'b0;
        fin_data        = '0;
        fin_status      = STAT_OK;
        mem_we          = 1'b0;
        mem_addr        = k_reg[IDX_W-1:0];
        mem_wdata       = '0;
        div_start       = 1'b0;

        case (state_reg)
            ST_CLR:
            begin
                mem_we = 1'b1;
                k_next = k_reg + CNT_W'(1);
                if (k_reg == CNT_W'(BINS - 1))
                begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                    fin        = clr_resp_reg;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    factor_next = factor;
                    k_next      = '0;
                    sum_next    = '0;
                    case (cmd_t'(command))
                        CMD_FILL:
                        begin
                            mem_addr = diff_u[IDX_W-1:0];
                            idx_next = diff_u[IDX_W-1:0];
                            if (fill_ok)
                            begin
                                state_next = ST_FILL;
                            end
                            else
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_RANGE;
                            end
                        end
                        CMD_READ:
                        begin
                            mem_addr = rd_ext[IDX_W-1:0];
                            if (rd_ok)
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        CMD_INTEGRAL:
                        begin
                            nrm_next   = 1'b0;
                            state_next = ST_SUM;
                        end
                        CMD_SCALE:     state_next = ST_SCL_RD;
                        CMD_NORMALIZE:
                        begin
                            nrm_next   = 1'b1;
                            state_next = ST_SUM;
                        end
                        CMD_CLEAR:
                        begin
                            clr_resp_next = 1'b1;
                            state_next    = ST_CLR;
                        end
                        default:       fin = 1'b1;
                    endcase
                end
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_addr  = idx_reg;
                mem_wdata = fill_sat;
                fin       = 1'b1;
            end
            ST_READ:
            begin
                fin      = 1'b1;
                fin_data = DATA_W'(mem_rdata);
            end
            ST_SUM:
            begin
                if (pend_reg)
                begin
                    sum_next = sum_reg + SUM_W'(mem_rdata);
                end
                if (k_reg < act_n)
                begin
                    k_next    = k_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    k_next = '0;
                    if (!nrm_reg)
                    begin
                        fin      = 1'b1;
                        fin_data = sum_sat;
                    end
                    else if (sum_reg == '0)
                    begin
                        fin        = 1'b1;
                        fin_status = STAT_ZERO;
                    end
                    else
                    begin
                        state_next = ST_NRM_RD;
                    end
                end
            end
            ST_SCL_RD:
            begin
                if (k_reg < act_n)
                begin
                    state_next = ST_SCL_MUL;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            ST_SCL_MUL:
            begin
                prod_next  = mul_res;
                state_next = ST_SCL_WR;
            end
            ST_SCL_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = scl_q;
                k_next     = k_reg + CNT_W'(1);
                state_next = ST_SCL_RD;
            end
            ST_NRM_RD:
            begin
                if (k_reg < act_n)
                begin
                    state_next = ST_NRM_MUL;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            ST_NRM_MUL:
            begin
                prod_next  = mul_res;
                state_next = ST_NRM_GO;
            end
            ST_NRM_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_NRM_DIV;
            end
            ST_NRM_DIV:
            begin
                if (div_done)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = div_quo;
                    k_next     = k_reg + CNT_W'(1);
                    state_next = ST_NRM_RD;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = out_free ? ST_IDLE : ST_RESP;
        end
    end

    // result beat: straight into the output register, or parked until free
    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        data_next       = data_reg;
        status_next     = status_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        if (fin)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                data_next      = fin_data;
                status_next    = fin_status;
            end
            else
            begin
                res_data_next   = fin_data;
                res_status_next = fin_status;
            end
        end
        else if (state_reg == ST_RESP && out_free)
        begin
            out_valid_next = 1'b1;
            data_next      = res_data_reg;
            status_next    = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            clr_resp_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            clr_resp_reg  <= clr_resp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nrm_reg        <= nrm_next;
        idx_reg        <= idx_next;
        factor_reg     <= factor_next;
        sum_reg        <= sum_next;
        prod_reg       <= prod_next;
        data_reg       <= data_next;
        status_reg     <= status_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign status    = status_reg;

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_NRM_DIV)
        else $error("divider finished outside the normalize wait");

    a_reset_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR && !clr_resp_reg) |=> !$rose(out_valid_reg))
        else $error("reset clearing pass produced a result beat");

    a_bin_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCL_RD || state_reg == ST_NRM_RD) |-> k_reg <= act_n)
        else $error("bin walk ran past the active bin count");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for histogram_engine
// Directed tests walk the empty store, fill limits, bin saturation, the
// active window, clear and an inverted window. Random traffic then runs
// under several register settings while both sides idle at random. Every
// result beat is checked against a predicted copy of the bin store.
// ----------------------------------------------------------------------------
module tb;
    import hist_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_W-1:0]     CMD_UNUSED_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
    localparam int                   CYCLE_LIMIT   = 3_000_000;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [STAT_W-1:0] status;
    } hist_reply_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index    = '0;
    logic [CFG_DATA_W-1:0]       cfg_data     = '0;
    logic                        in_valid     = 1'b0;
    logic                        in_stall;
    logic [CMD_W-1:0]            command      = '0;
    logic signed [SAMP_W-1:0]    sample_value = '0;
    logic [IDX_IN_W-1:0]         bin_index    = '0;
    logic [FACT_W-1:0]           factor       = '0;
    logic                        out_valid;
    logic                        out_stall    = 1'b0;
    logic [DATA_W-1:0]           data;
    logic [STAT_W-1:0]           status;

    // predicted store and registers
    logic [BIN_W-1:0]  bin_model [BINS_DEF];
    int                win_low   = 0;
    int                win_high  = 256;
    logic [BCNT_W-1:0] bin_limit = 9'd256;

    hist_reply_t awaited_replies[$];
    int          mismatches  = 0;
    int          reply_count = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    int          hold_cycles = 0;
    int          stall_mode  = 0;
    int          stall_run   = 0;

    histogram_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .sample_value (sample_value),
        .bin_index    (bin_index),
        .factor       (factor),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data         (data),
        .status       (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: long hold-off when requested, otherwise a stall pattern of its own
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else
        begin
            if (stall_run == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_run  = $urandom_range(8, 64);
            end
            stall_run--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        hist_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            reply_count++;
            if (awaited_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %0d: data %h status %0d",
                             reply_count, data, status);
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (data !== want.data || status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: data exp %h got %h, status exp %0d got %0d",
                                 reply_count, want.data, data, want.status, status);
                end
            end
        end
    end

    function automatic int active_bins();
        return (bin_limit < BINS_DEF) ? int'(bin_limit) : BINS_DEF;
    endfunction

    function automatic logic [63:0] bin_total();
        logic [63:0] sum;
        sum = '0;
        for (int k = 0; k < active_bins(); k++)
            sum += 64'(bin_model[k]);
        return sum;
    endfunction

    function automatic logic [BIN_W-1:0] saturate_bin(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? '1 : v[BIN_W-1:0];
    endfunction

    // ties round up
    function automatic logic [63:0] round_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q, r;
        q = num / den;
        r = num % den;
        if (r >= den - r)
            q++;
        return q;
    endfunction

    task automatic apply_command(input logic [CMD_W-1:0] cmd,
                                 input logic signed [SAMP_W-1:0] smp,
                                 input logic [IDX_IN_W-1:0] idx,
                                 input logic [FACT_W-1:0] fac);
        hist_reply_t reply;
        int          n;
        int          offset;
        logic [63:0] total;
        n            = active_bins();
        reply.data   = '0;
        reply.status = STAT_OK;
        case (cmd)
            CMD_FILL:
            begin
                offset = int'(smp) - win_low;
                if (int'(smp) >= win_low && int'(smp) < win_high && offset < n)
                    bin_model[offset] = saturate_bin(64'(bin_model[offset]) + 64'(BIN_ONE));
                else
                    reply.status = STAT_RANGE;
            end
            CMD_READ:
                reply.data = DATA_W'(bin_model[idx]);
            CMD_INTEGRAL:
            begin
                total      = bin_total();
                reply.data = (total > 64'(DATA_MAX)) ? DATA_MAX : total[DATA_W-1:0];
            end
            CMD_SCALE:
                for (int k = 0; k < n; k++)
                    bin_model[k] = saturate_bin(round_div(64'(bin_model[k]) * 64'(fac),
                                                          64'd65536));
            CMD_NORMALIZE:
            begin
                total = bin_total();
                if (total == 0)
                    reply.status = STAT_ZERO;
                else
                    for (int k = 0; k < n; k++)
                        bin_model[k] = saturate_bin(round_div(64'(bin_model[k]) * 64'(fac),
                                                              total * 64'd256));
            end
            CMD_CLEAR:
                foreach (bin_model[k])
                    bin_model[k] = '0;
            default:
                ;
        endcase
        awaited_replies.push_back(reply);
    endtask

    // one input beat; bursts of random length with random gaps between them
    task automatic issue_command(input logic [CMD_W-1:0] cmd,
                                 input logic signed [SAMP_W-1:0] smp,
                                 input logic [IDX_IN_W-1:0] idx,
                                 input logic [FACT_W-1:0] fac);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        sample_value <= smp;
        bin_index    <= idx;
        factor       <= fac;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_command(cmd, smp, idx, fac);
    endtask

    task automatic pause_sender();
        @(negedge clk);
        in_valid   <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_for_replies();
        while (awaited_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_RANGE_LOW:  win_low   = int'($signed(value));
            CFG_RANGE_HIGH: win_high  = int'($signed(value));
            CFG_BIN_COUNT:  bin_limit = value[BCNT_W-1:0];
            default:        ;
        endcase
    endtask

    task automatic set_window(input int lo, input int hi, input int count);
        logic [6:0] upper;
        upper = 7'($urandom);
        pause_sender();
        wait_for_replies();
        write_register(CFG_RANGE_LOW, CFG_DATA_W'(lo));
        write_register(CFG_RANGE_HIGH, CFG_DATA_W'(hi));
        write_register(CFG_BIN_COUNT, {upper, BCNT_W'(count)});
    endtask

    task automatic random_command();
        int                       n, span, roll, norm_pm, scale_pm;
        logic [CMD_W-1:0]         cmd;
        logic signed [SAMP_W-1:0] smp;
        logic [IDX_IN_W-1:0]      idx;
        logic [FACT_W-1:0]        fac;
        n    = active_bins();
        span = win_high - win_low;
        if (span > n)
            span = n;
        // whole-store commands are slow on wide windows
        norm_pm  = (n <= 32) ? 50 : ((n <= 64) ? 12 : 2);
        scale_pm = (n <= 64) ? 40 : 15;
        roll     = $urandom_range(0, 999);
        if (roll < norm_pm)
            cmd = CMD_NORMALIZE;
        else if (roll < norm_pm + scale_pm)
            cmd = CMD_SCALE;
        else if (roll < norm_pm + scale_pm + 40)
            cmd = CMD_INTEGRAL;
        else if (roll < norm_pm + scale_pm + 55)
            cmd = CMD_CLEAR;
        else if (roll < norm_pm + scale_pm + 70)
            cmd = $urandom_range(0, 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
        else if (roll < 700)
            cmd = CMD_FILL;
        else
            cmd = CMD_READ;

        if (span > 0 && $urandom_range(0, 9) != 0)
            smp = SAMP_W'(win_low + int'($urandom_range(0, span - 1)));
        else
            smp = SAMP_W'($urandom);

        if (n > 0 && $urandom_range(0, 9) < 7)
            idx = IDX_IN_W'($urandom_range(0, n - 1));
        else
            idx = IDX_IN_W'($urandom);

        if (cmd == CMD_SCALE && $urandom_range(0, 4) != 0)
            fac = $urandom_range(32'h8000, 32'h28000);
        else if (cmd == CMD_NORMALIZE && $urandom_range(0, 4) != 0)
            fac = $urandom_range(32'h100, 32'h400_0000);
        else
            fac = $urandom;

        issue_command(cmd, smp, idx, fac);
    endtask

    task automatic test_empty_store();
        issue_command(CMD_INTEGRAL, '0, '0, '0);
        issue_command(CMD_NORMALIZE, '0, '0, 32'h0001_0000);
        issue_command(CMD_UNUSED_LO, '0, '0, '0);
        issue_command(CMD_UNUSED_HI, '1, '1, '1);
    endtask

    task automatic test_fill_limits();
        issue_command(CMD_FILL, 16'sd0, '0, '0);
        issue_command(CMD_FILL, 16'sd255, '0, '0);
        issue_command(CMD_FILL, 16'sd256, '0, '0);
        issue_command(CMD_FILL, -16'sd1, '0, '0);
        issue_command(CMD_READ, '0, 8'd255, '0);
    endtask

    task automatic test_saturation();
        issue_command(CMD_SCALE, '0, '0, '1);
        issue_command(CMD_SCALE, '0, '0, '1);
        issue_command(CMD_FILL, 16'sd0, '0, '0);
        issue_command(CMD_INTEGRAL, '0, '0, '0);
        issue_command(CMD_NORMALIZE, '0, '0, 32'h0001_0000);
        issue_command(CMD_READ, '0, 8'd0, '0);
    endtask

    // bins beyond the active count keep their content until clear
    task automatic test_window_and_clear();
        set_window(-32768, 32767, 2);
        issue_command(CMD_FILL, -16'sd32768, '0, '0);
        issue_command(CMD_FILL, -16'sd32766, '0, '0);
        issue_command(CMD_FILL, 16'sd32767, '0, '0);
        issue_command(CMD_READ, '0, 8'd255, '0);
        issue_command(CMD_SCALE, '0, '0, '0);
        issue_command(CMD_READ, '0, 8'd255, '0);
        issue_command(CMD_CLEAR, '0, '0, '0);
        issue_command(CMD_READ, '0, 8'd255, '0);
    endtask

    task automatic test_inverted_window();
        set_window(32767, -32768, 0);
        write_register(CFG_SPARE, CFG_DATA_W'($urandom));
        issue_command(CMD_FILL, 16'sd32767, '0, '0);
        issue_command(CMD_NORMALIZE, '0, '0, '1);
    endtask

    task automatic run_random(input int beats);
        repeat (beats) random_command();
    endtask

    task automatic test_random_traffic();
        int lo, hi;
        set_window(0, 256, 256);
        run_random(250);
        set_window(-32768, -32468, 256);
        run_random(250);
        set_window(-10, 6, 16);
        run_random(250);
        set_window(32759, 32767, 300);
        run_random(200);
        repeat (3)
        begin
            lo = int'($urandom_range(0, 65535)) - 32768;
            hi = lo + int'($urandom_range(1, 300));
            if (hi > 32767)
                hi = 32767;
            set_window(lo, hi, $urandom_range(1, 256));
            run_random(250);
        end
        set_window(1000, 1001, 1);
        run_random(130);
        set_window(5, 4, 3);
        run_random(40);
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        set_window(-4, 60, 64);
        hold_cycles = 400;
        run_random(80);
        pause_sender();
        wait_for_replies();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (bin_model[k])
            bin_model[k] = '0;
        test_empty_store();
        test_fill_limits();
        test_saturation();
        test_window_and_clear();
        test_inverted_window();
        test_random_traffic();
        test_backpressure();
        pause_sender();
        wait_for_replies();
        repeat (400) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
design/hist_pkg.sv
design/hist_ram.sv
design/hist_div.sv
design/histogram_engine.sv
dv/tb.sv
